FILE: hdl/sbcp_pkg.sv
// Package for the serial bootloader command parser: types, codes and constants.
package sbcp_pkg;

  localparam int unsigned PageBytesDefault = 64;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_data;
  } sbcp_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] flash_address;
    logic [15:0] fill_word;
    logic        last;
  } sbcp_out_t;

  localparam logic [1:0] FuncSerial  = 2'd0;
  localparam logic [1:0] FuncFlash   = 2'd1;
  localparam logic [1:0] FuncTimeout = 2'd2;

  localparam logic [2:0] KindTx    = 3'd0;
  localparam logic [2:0] KindErase = 3'd1;
  localparam logic [2:0] KindFill  = 3'd2;
  localparam logic [2:0] KindWrite = 3'd3;
  localparam logic [2:0] KindRead  = 3'd4;
  localparam logic [2:0] KindRange = 3'd5;
  localparam logic [2:0] KindStart = 3'd6;

  localparam logic [1:0] RegSig = 2'd0;
  localparam logic [1:0] RegDev = 2'd1;
  localparam logic [1:0] RegEnd = 2'd2;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChQm  = 8'h3F;
  localparam logic [7:0] ChY   = 8'h59;
  localparam logic [7:0] ChS   = 8'h53;

  // Command bytes from the host.
  localparam logic [7:0] CmdEnterProg = 8'h50;
  localparam logic [7:0] CmdLeaveProg = 8'h4C;
  localparam logic [7:0] CmdAutoInc   = 8'h61;
  localparam logic [7:0] CmdSetAddr   = 8'h41;
  localparam logic [7:0] CmdChipErase = 8'h65;
  localparam logic [7:0] CmdSelDevice = 8'h54;
  localparam logic [7:0] CmdReadSig   = 8'h73;
  localparam logic [7:0] CmdSwIdent   = 8'h53;
  localparam logic [7:0] CmdDevCodes  = 8'h74;
  localparam logic [7:0] CmdProgType  = 8'h70;
  localparam logic [7:0] CmdBlockInfo = 8'h62;
  localparam logic [7:0] CmdBlockLoad = 8'h42;
  localparam logic [7:0] CmdBlockRead = 8'h67;
  localparam logic [7:0] CmdExit      = 8'h45;

  // Reply sequence that the controller starts in the datapath.
  typedef enum logic [3:0] {
    SEQ_NONE, SEQ_CR, SEQ_Y, SEQ_QM, SEQ_RANGE, SEQ_SIG, SEQ_IDENT,
    SEQ_DEV, SEQ_PS, SEQ_SIZE, SEQ_EXIT, SEQ_START, SEQ_LOAD, SEQ_READ,
    SEQ_RELAY
  } sbcp_seq_e;

  typedef struct packed {
    logic      start;
    sbcp_seq_e seq;
    logic [7:0] data;
  } sbcp_cmd_t;

  typedef struct packed {
    logic busy;
  } sbcp_stat_t;

  function automatic logic [7:0] ident_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h41;
      3'd1: r = 8'h56;
      3'd2: r = 8'h52;
      3'd3: r = 8'h42;
      3'd4: r = 8'h4F;
      3'd5: r = 8'h4F;
      3'd6: r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/sbcp_ctrl.sv
// Parser controller: tracks argument progress and picks the reply sequence for each request.
module sbcp_ctrl #(
  parameter int unsigned PageBytes = sbcp_pkg::PageBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbcp_pkg::sbcp_in_t   in_data_i,
  input  logic                 dp_busy_i,
  output sbcp_pkg::sbcp_cmd_t  cmd_o,
  output logic                 buf_we_o,
  output logic [$clog2(PageBytes)-1:0] buf_addr_o,
  output logic                 addr_hi_we_o,
  output logic                 addr_lo_we_o,
  output logic                 cnt_hi_we_o,
  output logic                 cnt_lo_we_o,
  input  logic [15:0]          byte_count_i,
  input  logic                 read_more_i
);
  import sbcp_pkg::*;

  localparam int unsigned IdxW = $clog2(PageBytes);
  localparam logic [6:0] LoadMax = 7'(PageBytes);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001, M_ADDR = 6'b000010, M_TYPE = 6'b000100,
    M_HDR  = 6'b001000, M_LOAD = 6'b010000, M_READ = 6'b100000
  } mode_e;

  mode_e mode_q, mode_d;
  logic [1:0] arg_q, arg_d;
  logic is_load_q, is_load_d;
  logic [6:0] lidx_q, lidx_d;
  logic halted_q, halted_d;
  logic acc;

  assign in_stall_o = dp_busy_i;
  assign acc = in_valid_i && !dp_busy_i;
  assign buf_addr_o = lidx_q[IdxW-1:0];

  always_comb begin
    mode_d = mode_q; arg_d = arg_q; is_load_d = is_load_q;
    lidx_d = lidx_q; halted_d = halted_q;
    cmd_o = '{start: 1'b0, seq: SEQ_NONE, data: in_data_i.rx_data};
    buf_we_o = 1'b0; addr_hi_we_o = 1'b0; addr_lo_we_o = 1'b0;
    cnt_hi_we_o = 1'b0; cnt_lo_we_o = 1'b0;
    if (acc && !halted_q) begin
      if (in_data_i.func == FuncTimeout) begin
        cmd_o.start = 1'b1; cmd_o.seq = SEQ_START;
        halted_d = 1'b1; mode_d = M_IDLE;
      end else if (in_data_i.func == FuncFlash) begin
        if (mode_q == M_READ) begin
          cmd_o.start = 1'b1; cmd_o.seq = SEQ_RELAY;
          if (!read_more_i) mode_d = M_IDLE;
        end
      end else if (in_data_i.func == FuncSerial) begin
        case (mode_q)
          M_IDLE: begin
            cmd_o.start = 1'b1;
            case (in_data_i.rx_data)
              CmdEnterProg, CmdLeaveProg: cmd_o.seq = SEQ_CR;
              CmdAutoInc: cmd_o.seq = SEQ_Y;
              CmdSetAddr: begin cmd_o.seq = SEQ_NONE; mode_d = M_ADDR; arg_d = 2'd0; end
              CmdChipErase: cmd_o.seq = SEQ_RANGE;
              CmdSelDevice: begin cmd_o.seq = SEQ_NONE; mode_d = M_TYPE; end
              CmdReadSig: cmd_o.seq = SEQ_SIG;
              CmdSwIdent: cmd_o.seq = SEQ_IDENT;
              CmdDevCodes: cmd_o.seq = SEQ_DEV;
              CmdProgType: cmd_o.seq = SEQ_PS;
              CmdBlockInfo: cmd_o.seq = SEQ_SIZE;
              CmdBlockLoad, CmdBlockRead: begin
                cmd_o.seq = SEQ_NONE; mode_d = M_HDR; arg_d = 2'd0;
                is_load_d = (in_data_i.rx_data == CmdBlockLoad);
              end
              CmdExit: begin cmd_o.seq = SEQ_EXIT; halted_d = 1'b1; end
              ChEsc: cmd_o.seq = SEQ_NONE;
              default: cmd_o.seq = SEQ_QM;
            endcase
          end
          M_ADDR: begin
            if (arg_q == 2'd0) begin
              addr_hi_we_o = 1'b1; arg_d = 2'd1;
            end else begin
              addr_lo_we_o = 1'b1; arg_d = 2'd0; mode_d = M_IDLE;
              cmd_o.start = 1'b1; cmd_o.seq = SEQ_CR;
            end
          end
          M_TYPE: begin
            mode_d = M_IDLE; cmd_o.start = 1'b1; cmd_o.seq = SEQ_CR;
          end
          M_HDR: begin
            if (arg_q == 2'd0) begin
              cnt_hi_we_o = 1'b1; arg_d = 2'd1;
            end else if (arg_q == 2'd1) begin
              cnt_lo_we_o = 1'b1; arg_d = 2'd2;
            end else begin
              arg_d = 2'd0; lidx_d = '0;
              if (is_load_q) begin
                if (byte_count_i == 16'd0) begin
                  cmd_o.start = 1'b1; cmd_o.seq = SEQ_LOAD; mode_d = M_IDLE;
                end else mode_d = M_LOAD;
              end else if (byte_count_i == 16'd0) begin
                mode_d = M_IDLE;
              end else begin
                mode_d = M_READ; cmd_o.start = 1'b1; cmd_o.seq = SEQ_READ;
              end
            end
          end
          M_LOAD: begin
            buf_we_o = 1'b1; lidx_d = lidx_q + 7'd1;
            // The load size is clamped to one page.
            if (({9'd0, lidx_d} >= byte_count_i) || (lidx_d >= LoadMax)) begin
              mode_d = M_IDLE; cmd_o.start = 1'b1; cmd_o.seq = SEQ_LOAD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; arg_q <= '0; is_load_q <= 1'b0;
      lidx_q <= '0; halted_q <= 1'b0;
    end else begin
      mode_q <= mode_d; arg_q <= arg_d; is_load_q <= is_load_d;
      lidx_q <= lidx_d; halted_q <= halted_d;
    end
  end
endmodule

FILE: hdl/sbcp_dp.sv
// Datapath: address and count registers, page buffer and the result sequencer.
module sbcp_dp #(
  parameter int unsigned PageBytes = sbcp_pkg::PageBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbcp_pkg::sbcp_cmd_t  cmd_i,
  output logic                 busy_o,
  input  logic                 buf_we_i,
  input  logic [$clog2(PageBytes)-1:0] buf_addr_i,
  input  logic                 addr_hi_we_i,
  input  logic                 addr_lo_we_i,
  input  logic                 cnt_hi_we_i,
  input  logic                 cnt_lo_we_i,
  output logic [15:0]          byte_count_o,
  output logic                 read_more_o,
  input  logic [23:0]          sig_i,
  input  logic [7:0]           dev_i,
  input  logic [15:0]          end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sbcp_pkg::sbcp_out_t  out_data_o
);
  import sbcp_pkg::*;

  localparam int unsigned IdxW = $clog2(PageBytes);
  localparam logic [15:0] PageSize = 16'(PageBytes);

  logic [7:0] mem [PageBytes];
  logic [7:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;

  logic [15:0] taddr_q, taddr_d, base_q, base_d, cnt_q, cnt_d;
  sbcp_seq_e seq_q, seq_d;
  logic [6:0] step_q, step_d;
  logic [1:0] lo_q, lo_d;
  logic [7:0] data_q, data_d;
  logic ov_q, ov_d;
  sbcp_out_t od_q, od_d;
  logic emit;
  sbcp_out_t e;
  logic done;
  logic [15:0] cnt_dec;

  assign byte_count_o = cnt_q;
  assign cnt_dec = cnt_q - 16'd1;
  assign read_more_o = (cnt_dec != 16'd0);
  assign busy_o = (seq_q != SEQ_NONE) || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  always_ff @(posedge clk_i) begin
    if (buf_we_i) mem[buf_addr_i] <= cmd_i.data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Load: step 0 issues the erase. From step 64 each word takes three steps:
  // read the low byte, read the high byte, then issue the fill. The write
  // follows the last word and step 1 sends the CR.
  always_comb begin
    taddr_d = taddr_q; base_d = base_q; cnt_d = cnt_q;
    seq_d = seq_q; step_d = step_q; lo_d = lo_q; data_d = data_q;
    emit = 1'b0; done = 1'b0;
    e = '{kind: KindTx, tx_byte: 8'd0, flash_address: 16'd0, fill_word: 16'd0, last: 1'b0};
    rd_en = 1'b0; rd_addr = step_q[IdxW-1:0];
    if (addr_hi_we_i) taddr_d = {cmd_i.data, 8'd0};
    if (addr_lo_we_i) taddr_d = {taddr_q[14:8], cmd_i.data, 1'b0};
    if (cnt_hi_we_i) cnt_d = {cmd_i.data, 8'd0};
    if (cnt_lo_we_i) cnt_d = {cnt_q[15:8], cmd_i.data};
    if (cmd_i.start) begin
      seq_d = cmd_i.seq; step_d = '0; data_d = cmd_i.data;
      if (cmd_i.seq == SEQ_LOAD) begin
        base_d = taddr_q;
        if (cnt_q > PageSize) cnt_d = PageSize;
      end
    end else if (seq_q != SEQ_NONE && !(ov_q && out_stall_i)) begin
      step_d = step_q + 7'd1;
      case (seq_q)
        SEQ_CR: begin emit = 1'b1; e.tx_byte = ChCr; done = 1'b1; end
        SEQ_Y: begin emit = 1'b1; e.tx_byte = ChY; done = 1'b1; end
        SEQ_QM: begin emit = 1'b1; e.tx_byte = ChQm; done = 1'b1; end
        SEQ_PS: begin emit = 1'b1; e.tx_byte = ChS; done = 1'b1; end
        SEQ_START: begin emit = 1'b1; e.kind = KindStart; done = 1'b1; end
        SEQ_RANGE: begin
          emit = 1'b1;
          if (step_q == 7'd0) begin e.kind = KindRange; e.flash_address = end_i; end
          else begin e.tx_byte = ChCr; done = 1'b1; end
        end
        SEQ_EXIT: begin
          emit = 1'b1;
          if (step_q == 7'd0) e.tx_byte = ChCr;
          else begin e.kind = KindStart; done = 1'b1; end
        end
        SEQ_SIG: begin
          emit = 1'b1;
          case (step_q[1:0])
            2'd0: e.tx_byte = sig_i[23:16];
            2'd1: e.tx_byte = sig_i[15:8];
            default: begin e.tx_byte = sig_i[7:0]; done = 1'b1; end
          endcase
        end
        SEQ_IDENT: begin
          emit = 1'b1; e.tx_byte = ident_byte(step_q[2:0]);
          done = (step_q == 7'd6);
        end
        SEQ_DEV: begin
          emit = 1'b1;
          if (step_q == 7'd0) e.tx_byte = dev_i;
          else begin e.tx_byte = 8'd0; done = 1'b1; end
        end
        SEQ_SIZE: begin
          emit = 1'b1;
          case (step_q[1:0])
            2'd0: e.tx_byte = ChY;
            2'd1: e.tx_byte = PageSize[15:8];
            default: begin e.tx_byte = PageSize[7:0]; done = 1'b1; end
          endcase
        end
        SEQ_READ: begin
          emit = 1'b1;
          e.kind = KindRead; e.flash_address = taddr_q;
          taddr_d = taddr_q + 16'd1; done = 1'b1;
        end
        SEQ_RELAY: begin
          // Relay the flash byte to the host, then request the next one if any remain.
          emit = 1'b1;
          if (step_q == 7'd0) begin
            e.tx_byte = data_q; cnt_d = cnt_dec; done = !read_more_o;
          end else begin
            e.kind = KindRead; e.flash_address = taddr_q;
            taddr_d = taddr_q + 16'd1; done = 1'b1;
          end
        end
        SEQ_LOAD: begin
          if (step_q == 7'd0) begin
            emit = 1'b1; e.kind = KindErase; e.flash_address = base_q;
            step_d = 7'd64; lo_d = 2'b00;
          end else if (step_q[6]) begin
            step_d = step_q;
            if (taddr_q - base_q >= cnt_q) begin
              emit = 1'b1; e.kind = KindWrite; e.flash_address = base_q;
              step_d = 7'd1;
            end else if (!lo_q[0]) begin
              rd_en = 1'b1; rd_addr = IdxW'(taddr_q - base_q);
              lo_d = 2'b01;
            end else if (!lo_q[1]) begin
              data_d = rd_q;
              rd_en = 1'b1; rd_addr = IdxW'(taddr_q - base_q + 16'd1);
              lo_d = 2'b11;
            end else begin
              emit = 1'b1; e.kind = KindFill; e.flash_address = taddr_q;
              e.fill_word = {(taddr_q - base_q + 16'd1 < cnt_q) ? rd_q : 8'hFF, data_q};
              taddr_d = taddr_q + 16'd2; lo_d = 2'b00;
            end
          end else begin
            emit = 1'b1; e.tx_byte = ChCr; done = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
      e.last = done;
      if (done) seq_d = SEQ_NONE;
    end
    ov_d = ov_q; od_d = od_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (emit) begin ov_d = 1'b1; od_d = e; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_NONE; ov_q <= 1'b0; step_q <= '0; lo_q <= '0;
      taddr_q <= '0; cnt_q <= '0;
    end else begin
      ov_q <= ov_d; step_q <= step_d; lo_q <= lo_d;
      taddr_q <= taddr_d; cnt_q <= cnt_d; seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; data_q <= data_d; od_q <= od_d;
  end
endmodule

FILE: hdl/serial_bootloader_command_parser_top.sv
// Top level of the serial bootloader command parser with its register port.
//  channel | direction | payload     | handshake
//  in      | input     | sbcp_in_t   | in_valid_i / in_stall_o
//  out     | output    | sbcp_out_t  | out_valid_o / out_stall_i
//  apb     | input     | 3 regs      | psel / penable / pready
// Results are issued one per cycle unless the output stalls; a page load
// pauses to read both bytes of each word from the single buffer read port.
// Input is stalled while results remain to be issued or a result waits on a
// stalled output. Reset clears all control state; the page buffer holds no
// reset value.
module serial_bootloader_command_parser_top #(
  parameter int unsigned PageBytes = sbcp_pkg::PageBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbcp_pkg::sbcp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbcp_pkg::sbcp_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sbcp_pkg::*;

  localparam int unsigned IdxW = $clog2(PageBytes);

  logic [23:0] sig_q;
  logic [7:0] dev_q;
  logic [15:0] end_q;
  sbcp_cmd_t cmd;
  logic busy, buf_we, ahw, alw, chw, clw, more;
  logic [IdxW-1:0] baddr;
  logic [15:0] bcnt;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      RegSig: prdata = {8'd0, sig_q};
      RegDev: prdata = {24'd0, dev_q};
      RegEnd: prdata = {16'd0, end_q};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= '0; dev_q <= '0; end_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegSig: sig_q <= pwdata[23:0];
        RegDev: dev_q <= pwdata[7:0];
        RegEnd: end_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  sbcp_ctrl #(.PageBytes(PageBytes)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .dp_busy_i(busy), .cmd_o(cmd), .buf_we_o(buf_we),
    .buf_addr_o(baddr), .addr_hi_we_o(ahw), .addr_lo_we_o(alw),
    .cnt_hi_we_o(chw), .cnt_lo_we_o(clw),
    .byte_count_i(bcnt), .read_more_i(more)
  );

  sbcp_dp #(.PageBytes(PageBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .busy_o(busy), .buf_we_i(buf_we),
    .buf_addr_i(baddr), .addr_hi_we_i(ahw), .addr_lo_we_i(alw),
    .cnt_hi_we_i(chw), .cnt_lo_we_i(clw),
    .byte_count_o(bcnt), .read_more_o(more), .sig_i(sig_q), .dev_i(dev_q),
    .end_i(end_q), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );
endmodule

FILE: hdl/sbcp_check.sv
// Port-level checker for the command parser, bound to the top level.
module sbcp_check (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pready
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("request taken while stalled");
endmodule

bind serial_bootloader_command_parser_top sbcp_check u_check (.*);
